// ----- rtl/dape_pkg.sv -----
// Shared types, constants and helper functions of the DAG path enumerator.
package dape_pkg;

    localparam int VTX_W      = 6;
    localparam int ROW_W      = 64;
    localparam int CNT_W      = 17;
    localparam int LIM_W      = 16;
    localparam int VCNT_W     = 7;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 16;

    localparam int MAX_VERTICES_DEF = 64;

    localparam logic [VCNT_W-1:0] VERTEX_COUNT_RST = 7'd64;
    localparam logic [LIM_W-1:0]  PATH_LIMIT_RST   = 16'd1500;

    // Item kinds
    localparam logic [1:0] KIND_LOAD  = 2'd0;
    localparam logic [1:0] KIND_START = 2'd1;
    localparam logic [1:0] KIND_NEXT  = 2'd2;

    // Result status codes
    localparam logic [1:0] STATUS_PATH     = 2'd0;
    localparam logic [1:0] STATUS_FINISHED = 2'd1;
    localparam logic [1:0] STATUS_LIMIT    = 2'd2;
    localparam logic [1:0] STATUS_ACK      = 2'd3;

    // Search phases
    localparam logic [1:0] PHASE_IDLE = 2'd0;
    localparam logic [1:0] PHASE_RUN  = 2'd1;
    localparam logic [1:0] PHASE_DONE = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_VERTEX_COUNT = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PATH_LIMIT   = 4'd1;

    typedef struct packed {
        logic [1:0]       kind;
        logic [VTX_W-1:0] row_index;
        logic [ROW_W-1:0] row_bits;
    } item_t;

    typedef struct packed {
        logic [1:0]       status;
        logic [ROW_W-1:0] path_mask;
        logic [VTX_W-1:0] path_length;
        logic [CNT_W-1:0] path_count;
    } result_t;

    typedef struct packed {
        logic [CFG_IDX_W-1:0]  index;
        logic [CFG_DATA_W-1:0] value;
    } cfg_t;

    // Controller to datapath
    typedef struct packed {
        logic latch;
        logic decode;
        logic reach;
        logic walk;
        logic emit;
    } dape_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic [1:0] kind;
        logic       run;
        logic       reach_last;
        logic       walk_done;
        logic       out_free;
    } dape_stat_t;

    // Bits below position n set; n of 64 or more gives all ones
    function automatic logic [ROW_W-1:0] low_mask(input logic [VCNT_W-1:0] n);
        logic [ROW_W-1:0] m;
        for (int i = 0; i < ROW_W; i++)
            m[i] = (VCNT_W'(i) < n);
        return m;
    endfunction

    function automatic logic [VTX_W-1:0] lowest_set(input logic [ROW_W-1:0] v);
        logic [VTX_W-1:0] idx;
        idx = '0;
        for (int i = ROW_W - 1; i >= 0; i--)
            if (v[i])
                idx = VTX_W'(i);
        return idx;
    endfunction

    function automatic logic [VTX_W-1:0] highest_set(input logic [ROW_W-1:0] v);
        logic [VTX_W-1:0] idx;
        idx = '0;
        for (int i = 0; i < ROW_W; i++)
            if (v[i])
                idx = VTX_W'(i);
        return idx;
    endfunction

endpackage

// ----- rtl/dape_stream_if.sv -----
// Valid/ready stream interface carrying one payload beat.
interface dape_stream_if #(parameter type payload_t = logic);

    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);

endinterface

// ----- rtl/dape_ctrl.sv -----
// Sequencing state machine of the DAG path enumerator.
module dape_ctrl
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  dape_pkg::dape_stat_t   stat,
    output dape_pkg::dape_cmd_t    cmd
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_DECODE = 3'd1;
    localparam logic [2:0] S_REACH  = 3'd2;
    localparam logic [2:0] S_WALK   = 3'd3;
    localparam logic [2:0] S_EMIT   = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                    state_next = S_DECODE;
            end
            S_DECODE:
            begin
                if (stat.kind == dape_pkg::KIND_NEXT && stat.run)
                    state_next = S_REACH;
                else
                    state_next = S_EMIT;
            end
            S_REACH:
            begin
                if (stat.reach_last)
                    state_next = S_WALK;
            end
            S_WALK:
            begin
                if (stat.walk_done)
                    state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (stat.out_free)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    assign in_ready   = (state_reg == S_IDLE);
    assign cmd.latch  = (state_reg == S_IDLE) && in_valid;
    assign cmd.decode = (state_reg == S_DECODE);
    assign cmd.reach  = (state_reg == S_REACH);
    assign cmd.walk   = (state_reg == S_WALK);
    assign cmd.emit   = (state_reg == S_EMIT);

    // A search step only follows a next request on a running search
    a_reach_entry: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_REACH && $past(state_reg) != S_REACH |->
            $past(stat.kind) == dape_pkg::KIND_NEXT)
        else $error("reach scan entered without a next request");

    a_walk_entry: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_WALK |-> $past(state_reg) == S_REACH || $past(state_reg) == S_WALK)
        else $error("walk entered without a reach scan");

    a_accept_after_emit: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.latch |-> $past(state_reg) == S_EMIT || $past(state_reg) == S_IDLE)
        else $error("item taken while a result was still pending");

endmodule

// ----- rtl/dape_dp.sv -----
// Datapath of the DAG path enumerator: adjacency store, reach scan and walk.
module dape_dp #(
    parameter int MAX_VERTICES = dape_pkg::MAX_VERTICES_DEF
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  dape_pkg::dape_cmd_t                 cmd,
    output dape_pkg::dape_stat_t                stat,
    input  dape_pkg::item_t                     in_data,
    input  logic [dape_pkg::VCNT_W-1:0]         vertex_count,
    input  logic [dape_pkg::LIM_W-1:0]          path_limit,
    output logic                                out_valid,
    input  logic                                out_ready,
    output dape_pkg::result_t                   out_data
);

    localparam int AW  = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
    localparam int VW  = dape_pkg::VCNT_W;
    localparam int VXW = dape_pkg::VTX_W;
    localparam int RW  = dape_pkg::ROW_W;
    localparam int CW  = dape_pkg::CNT_W;
    localparam logic [VW-1:0] VC_MAX = VW'(MAX_VERTICES);

    // Adjacency store, one row per vertex, with a valid bit per row
    logic [RW-1:0]           adj_mem [MAX_VERTICES];
    logic [MAX_VERTICES-1:0] row_valid_reg, row_valid_next;
    logic [RW-1:0]           rd_row_reg;
    logic                    rd_ok_reg;
    logic [VXW-1:0]          rd_addr;
    logic                    mem_we;

    dape_pkg::item_t   in_reg;
    dape_pkg::result_t res_reg, res_next;
    dape_pkg::result_t out_data_reg;
    logic              out_valid_reg, out_valid_next;

    logic [1:0]     phase_reg, phase_next;
    logic [VW-1:0]  depth_reg, depth_next;
    logic [CW-1:0]  count_reg, count_next;
    // Forward-only edges keep the stack strictly ascending, so the set of
    // stacked vertices fixes the node stack; the top is its highest bit.
    logic [RW-1:0]  onstack_reg, onstack_next;
    logic [VXW-1:0] top_reg, top_next;
    logic [VW-1:0]  cand_reg, cand_next;
    logic [RW-1:0]  reach_reg, reach_next;
    logic [VXW-1:0] scan_reg, scan_next;

    logic [VW-1:0]  vc_eff;
    logic [VXW-1:0] sink;
    logic [RW-1:0]  sink_bit, top_bit, scan_bit;
    logic [RW-1:0]  row, cand_bits, stack_pop, path_bits;
    logic [VXW-1:0] first_cand, parent;
    logic [CW-1:0]  count_inc;
    logic [VXW-1:0] plen;
    logic           at_sink, depth_zero, can_push, over, in_range, out_free;

    always_comb
    begin
        if (vertex_count < VW'(2))
            vc_eff = VW'(2);
        else if (vertex_count > VC_MAX)
            vc_eff = VC_MAX;
        else
            vc_eff = vertex_count;
        sink       = VXW'(vc_eff - VW'(1));
        sink_bit   = RW'(1) << sink;
        top_bit    = RW'(1) << top_reg;
        scan_bit   = RW'(1) << scan_reg;
        row        = rd_ok_reg ? rd_row_reg : '0;
        cand_bits  = row & reach_reg & ~dape_pkg::low_mask(cand_reg);
        first_cand = dape_pkg::lowest_set(cand_bits);
        stack_pop  = onstack_reg & ~top_bit;
        parent     = dape_pkg::highest_set(stack_pop);
        path_bits  = stack_pop & ~RW'(1);
        plen       = VXW'(depth_reg - VW'(2));
        count_inc  = count_reg + CW'(1);
        over       = count_inc > CW'(path_limit);
        at_sink    = (top_reg == sink);
        depth_zero = (depth_reg == '0);
        can_push   = (|cand_bits) && !depth_reg[VW-1];
        in_range   = {1'b0, in_reg.row_index} < VC_MAX;
        out_free   = !out_valid_reg || out_ready;
    end

    always_comb
    begin
        row_valid_next = row_valid_reg;
        phase_next     = phase_reg;
        depth_next     = depth_reg;
        count_next     = count_reg;
        onstack_next   = onstack_reg;
        top_next       = top_reg;
        cand_next      = cand_reg;
        reach_next     = reach_reg;
        scan_next      = scan_reg;
        res_next       = res_reg;
        rd_addr        = top_reg;
        mem_we         = 1'b0;

        if (cmd.decode)
        begin
            res_next.status      = dape_pkg::STATUS_ACK;
            res_next.path_mask   = '0;
            res_next.path_length = '0;
            res_next.path_count  = count_reg;
            case (in_reg.kind)
                dape_pkg::KIND_LOAD:
                begin
                    // Write the row and drop any search in flight
                    mem_we = in_range;
                    if (in_range)
                        row_valid_next[in_reg.row_index[AW-1:0]] = 1'b1;
                    phase_next          = dape_pkg::PHASE_IDLE;
                    depth_next          = '0;
                    count_next          = '0;
                    res_next.path_count = '0;
                end
                dape_pkg::KIND_START:
                begin
                    onstack_next        = RW'(1);
                    top_next            = '0;
                    cand_next           = VW'(1);
                    depth_next          = VW'(1);
                    count_next          = '0;
                    phase_next          = dape_pkg::PHASE_RUN;
                    res_next.path_count = '0;
                end
                dape_pkg::KIND_NEXT:
                begin
                    if (phase_reg == dape_pkg::PHASE_RUN)
                    begin
                        reach_next = sink_bit;
                        scan_next  = sink - VXW'(1);
                        rd_addr    = sink - VXW'(1);
                    end
                    else
                    begin
                        res_next.status = dape_pkg::STATUS_FINISHED;
                    end
                end
                default:
                begin
                    res_next.status = dape_pkg::STATUS_ACK;
                end
            endcase
        end

        if (cmd.reach)
        begin
            if (|(row & reach_reg))
                reach_next = reach_reg | scan_bit;
            if (scan_reg == '0)
            begin
                rd_addr = top_reg;
            end
            else
            begin
                scan_next = scan_reg - VXW'(1);
                rd_addr   = scan_reg - VXW'(1);
            end
        end

        if (cmd.walk)
        begin
            res_next.path_mask   = '0;
            res_next.path_length = '0;
            res_next.path_count  = count_reg;
            if (depth_zero)
            begin
                phase_next      = dape_pkg::PHASE_DONE;
                res_next.status = dape_pkg::STATUS_FINISHED;
            end
            else if (at_sink)
            begin
                count_next           = count_inc;
                res_next.path_mask   = path_bits;
                res_next.path_length = plen;
                res_next.path_count  = count_inc;
                if (over)
                begin
                    phase_next      = dape_pkg::PHASE_DONE;
                    res_next.status = dape_pkg::STATUS_LIMIT;
                end
                else
                begin
                    res_next.status = dape_pkg::STATUS_PATH;
                    depth_next      = depth_reg - VW'(1);
                    onstack_next    = stack_pop;
                    cand_next       = VW'(top_reg) + VW'(1);
                    top_next        = parent;
                end
            end
            else if (can_push)
            begin
                onstack_next = onstack_reg | (RW'(1) << first_cand);
                top_next     = first_cand;
                cand_next    = VW'(first_cand) + VW'(1);
                depth_next   = depth_reg + VW'(1);
                rd_addr      = first_cand;
            end
            else
            begin
                // Pop: the parent resumes just above the vertex left
                onstack_next = stack_pop;
                depth_next   = depth_reg - VW'(1);
                cand_next    = VW'(top_reg) + VW'(1);
                top_next     = parent;
                rd_addr      = parent;
            end
        end

        if (cmd.emit && out_free)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            adj_mem[in_reg.row_index[AW-1:0]] <= in_reg.row_bits;
        rd_row_reg <= adj_mem[rd_addr[AW-1:0]];
        rd_ok_reg  <= row_valid_reg[rd_addr[AW-1:0]];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_valid_reg <= '0;
            phase_reg     <= dape_pkg::PHASE_IDLE;
            depth_reg     <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            row_valid_reg <= row_valid_next;
            phase_reg     <= phase_next;
            depth_reg     <= depth_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.latch)
            in_reg <= in_data;
        if (cmd.emit && out_free)
            out_data_reg <= res_reg;
        onstack_reg <= onstack_next;
        top_reg     <= top_next;
        cand_reg    <= cand_next;
        reach_reg   <= reach_next;
        scan_reg    <= scan_next;
        res_reg     <= res_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    assign stat.kind       = in_reg.kind;
    assign stat.run        = (phase_reg == dape_pkg::PHASE_RUN);
    assign stat.reach_last = (scan_reg == '0);
    assign stat.walk_done  = depth_zero || at_sink;
    assign stat.out_free   = out_free;

    a_stack_size: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == dape_pkg::PHASE_RUN |-> $countones(onstack_reg) == int'(depth_reg))
        else $error("stacked vertex set disagrees with depth");

    a_top_highest: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == dape_pkg::PHASE_RUN && depth_reg != '0 |->
            (onstack_reg >> top_reg) == RW'(1))
        else $error("top of stack is not the highest stacked vertex");

    a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
        depth_reg <= VW'(64))
        else $error("stack depth beyond 64");

    a_path_length: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && (out_data_reg.status == dape_pkg::STATUS_PATH ||
                          out_data_reg.status == dape_pkg::STATUS_LIMIT) |->
            $countones(out_data_reg.path_mask) == int'(out_data_reg.path_length))
        else $error("path length disagrees with path mask");

endmodule

// ----- rtl/dag_all_paths_enumerator.sv -----
// Top level of the DAG path enumerator: configuration registers and the two engines.
//
//  Channel     Dir  Beat contents                          Notes
//  item_in     in   kind, row_index, row_bits              load / start / next
//  result_out  out  status, path_mask, path_length, count  one beat per item
//  cfg         in   index, value                           0 vertex_count, 1 path_limit
//
// Load, start, the unused kind and a next request with no running search pass
// through decode and emit. A next request on a running search scans adjacency rows
// for the reach set from just below the sink down to the source, then walks one push
// or pop per step, bounded by the single read port of the adjacency store.
// Reset clears the row valid bits at once, so no clearing pass is needed.
// The next item is taken while a result still waits on result_out; a stalled
// result only holds the block once a second result is ready behind it.
module dag_all_paths_enumerator #(
    parameter int MAX_VERTICES = dape_pkg::MAX_VERTICES_DEF
)
(
    input  logic          clk,
    input  logic          rst_n,
    dape_stream_if.sink   item_in,
    dape_stream_if.source result_out,
    dape_stream_if.sink   cfg
);

    logic [dape_pkg::VCNT_W-1:0] vertex_count_reg;
    logic [dape_pkg::LIM_W-1:0]  path_limit_reg;

    dape_pkg::dape_cmd_t  cmd;
    dape_pkg::dape_stat_t stat;
    dape_pkg::result_t    result;

    // Configuration is always taken; an unknown index is dropped
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vertex_count_reg <= dape_pkg::VERTEX_COUNT_RST;
            path_limit_reg   <= dape_pkg::PATH_LIMIT_RST;
        end
        else if (cfg.valid)
        begin
            case (cfg.data.index)
                dape_pkg::REG_VERTEX_COUNT:
                begin
                    vertex_count_reg <= cfg.data.value[dape_pkg::VCNT_W-1:0];
                end
                dape_pkg::REG_PATH_LIMIT:
                begin
                    path_limit_reg <= cfg.data.value[dape_pkg::LIM_W-1:0];
                end
                default:
                begin
                    path_limit_reg <= path_limit_reg;
                end
            endcase
        end
    end

    // Sequencer: accept, decode, scan reach set, walk, hand over the result
    dape_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (item_in.valid),
        .in_ready (item_in.ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // Adjacency store, depth-first walk state and the output register
    dape_dp #(
        .MAX_VERTICES (MAX_VERTICES)
    ) u_dp
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .in_data      (item_in.data),
        .vertex_count (vertex_count_reg),
        .path_limit   (path_limit_reg),
        .out_valid    (result_out.valid),
        .out_ready    (result_out.ready),
        .out_data     (result)
    );

    assign result_out.data = result;

endmodule
